// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the core files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge outside reset
`define CSP_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/csp_pkg.sv =====
`timescale 1ns / 1ps
package csp_pkg;

  localparam int unsigned MAX_COLUMNS = 65536;
  localparam logic [16:0] COLUMN_LIMIT_RESET = 17'h10000;

  localparam logic [7:0] TAG_TABLE = 8'h54;
  localparam logic [7:0] OP_INSERT = 8'h12;
  localparam logic [7:0] OP_UPDATE = 8'h17;
  localparam logic [7:0] OP_DELETE = 8'h09;

  localparam logic [7:0] FT_UNDEF = 8'd0;
  localparam logic [7:0] FT_INT   = 8'd1;
  localparam logic [7:0] FT_REAL  = 8'd2;
  localparam logic [7:0] FT_TEXT  = 8'd3;
  localparam logic [7:0] FT_BLOB  = 8'd4;
  localparam logic [7:0] FT_NULL  = 8'd5;

  localparam logic [3:0] PH_TOP      = 4'd0;
  localparam logic [3:0] PH_COUNT    = 4'd1;
  localparam logic [3:0] PH_PK       = 4'd2;
  localparam logic [3:0] PH_NAME     = 4'd3;
  localparam logic [3:0] PH_INDIRECT = 4'd4;
  localparam logic [3:0] PH_FTYPE    = 4'd5;
  localparam logic [3:0] PH_FIXED    = 4'd6;
  localparam logic [3:0] PH_LEN      = 4'd7;
  localparam logic [3:0] PH_PAYLOAD  = 4'd8;
  localparam logic [3:0] PH_HALT     = 4'd9;

  localparam logic [3:0] K_HEADER  = 4'd0;
  localparam logic [3:0] K_PK      = 4'd1;
  localparam logic [3:0] K_NAMEB   = 4'd2;
  localparam logic [3:0] K_NAMEEND = 4'd3;
  localparam logic [3:0] K_OP      = 4'd4;
  localparam logic [3:0] K_NULL    = 4'd5;
  localparam logic [3:0] K_UNDEF   = 4'd6;
  localparam logic [3:0] K_INT     = 4'd7;
  localparam logic [3:0] K_REAL    = 4'd8;
  localparam logic [3:0] K_TEXT    = 4'd9;
  localparam logic [3:0] K_BLOB    = 4'd10;
  localparam logic [3:0] K_PAYLOAD = 4'd11;
  localparam logic [3:0] K_ERROR   = 4'd12;
  localparam logic [3:0] K_END     = 4'd13;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_COLUMNS   = 2'd1;
  localparam logic [1:0] ERR_FIELDTYPE = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } csp_item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [63:0] token_value;
    logic [15:0] column_index;
    logic        in_new_row;
    logic        entry_done;
    logic [1:0]  error_code;
  } csp_token_t;

  // handshake between the input register and the parse step
  typedef struct packed {
    logic valid;
    logic go;
  } csp_stage_t;

endpackage

// ===== rtl/core/changeset_stream_parser_core.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Byte-serial changeset parser: one word (a changeset byte or an end mark) is taken per
// cycle and at most one token word comes out for it, through the input and result registers;
// a word may be accepted every cycle as long as tokens are taken. The rate is set by the
// single parse step that updates the phase, column and varint registers from one
// registered byte. column_limit is written through the cfg channel, which is always ready;
// the user must write it only while the parser is idle, which the block does not enforce.
module changeset_stream_parser_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  csp_pkg::csp_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output csp_pkg::csp_token_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [16:0]         cfg_data
);
  import csp_pkg::*;

  logic        down_free;
  csp_stage_t  stage;
  csp_item_t   item;
  logic        emit;
  csp_token_t  token;
  logic [16:0] column_limit;

  assign cfg_ready = 1'b1;
  assign down_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_limit <= COLUMN_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      column_limit <= cfg_data;
    end
  end

  csp_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .down_free (down_free),
    .stage     (stage),
    .item      (item)
  );

  csp_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (stage.go),
    .item         (item),
    .column_limit (column_limit),
    .emit         (emit),
    .token        (token)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage.go && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage.go && emit) begin
      out_data <= token;
    end
  end

  `CSP_ASSERT_IMP(a_err_code, out_valid && out_data.token_kind == K_ERROR, out_data.error_code != ERR_NONE, "error token without code")
  `CSP_ASSERT_IMP(a_no_code, out_valid && out_data.token_kind != K_ERROR, out_data.error_code == ERR_NONE, "code on non-error token")
  `CSP_ASSERT_IMP(a_done_kind, out_valid && out_data.entry_done, out_data.token_kind == K_OP || out_data.token_kind == K_NULL || out_data.token_kind == K_UNDEF || out_data.token_kind == K_INT || out_data.token_kind == K_REAL || out_data.token_kind == K_TEXT || out_data.token_kind == K_BLOB || out_data.token_kind == K_PAYLOAD, "entry done on wrong token")
  `CSP_ASSERT_NXT(a_stage_hold, stage.valid && out_valid && !out_ready, stage.valid, "input word lost while blocked")

endmodule

// ===== rtl/core/csp_in_reg.sv =====
`timescale 1ns / 1ps
module csp_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  csp_pkg::csp_item_t in_data,
  input  logic               down_free,
  output csp_pkg::csp_stage_t stage,
  output csp_pkg::csp_item_t item
);
  import csp_pkg::*;

  logic      held;
  csp_item_t held_data;

  assign stage.valid = held;
  assign stage.go    = held && down_free;
  assign in_ready    = !held || down_free;
  assign item        = held_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (stage.go) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_data <= in_data;
    end
  end

endmodule

// ===== rtl/core/csp_parser.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module csp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  csp_pkg::csp_item_t  item,
  input  logic [16:0]         column_limit,
  output logic                emit,
  output csp_pkg::csp_token_t token
);
  import csp_pkg::*;

  logic [3:0]  parse_phase, parse_phase_next;
  logic [16:0] column_count, column_count_next;
  logic [16:0] column_position, column_position_next;
  logic [7:0]  change_op, change_op_next;
  logic        record_side, record_side_next;
  logic [2:0]  field_type, field_type_next;
  logic [31:0] varint_accum, varint_accum_next;
  logic [3:0]  varint_bytes, varint_bytes_next;
  logic [63:0] value_shift, value_shift_next;
  logic [31:0] byte_counter, byte_counter_next;

  logic [7:0]  b;
  logic [39:0] vt_wide;
  logic [31:0] vt_sat;
  logic        vt_done;
  logic [16:0] pos_inc;
  logic        ff_last, ff_flip, ff_done;
  logic        fin;

  assign b = item.in_byte;

  // varint step: 7 bits per byte, the ninth byte carries all 8
  always_comb begin
    if (varint_bytes >= 4'd8) begin
      vt_wide = {varint_accum, b};
    end else begin
      vt_wide = {1'b0, varint_accum, b[6:0]};
    end
    vt_sat  = (|vt_wide[39:32]) ? 32'hFFFF_FFFF : vt_wide[31:0];
    vt_done = (varint_bytes >= 4'd8) || !b[7];
  end

  // end-of-field bookkeeping
  always_comb begin
    pos_inc = column_position + 17'd1;
    ff_last = pos_inc >= column_count;
    ff_flip = ff_last && !record_side && (change_op == OP_UPDATE);
    ff_done = ff_last && !ff_flip;
  end

  always_comb begin
    parse_phase_next     = parse_phase;
    column_count_next    = column_count;
    column_position_next = column_position;
    change_op_next       = change_op;
    record_side_next     = record_side;
    field_type_next      = field_type;
    varint_accum_next    = varint_accum;
    varint_bytes_next    = varint_bytes;
    value_shift_next     = value_shift;
    byte_counter_next    = byte_counter;
    emit                 = 1'b0;
    token                = '0;
    fin                  = 1'b0;

    if (item.stream_end) begin
      parse_phase_next = PH_TOP;
      emit             = 1'b1;
      if (parse_phase == PH_TOP || parse_phase == PH_HALT) begin
        token.token_kind = K_END;
      end else begin
        token.token_kind = K_ERROR;
        token.error_code = ERR_TRUNCATED;
      end
    end else begin
      case (parse_phase)
        PH_TOP: begin
          if (b == TAG_TABLE) begin
            parse_phase_next  = PH_COUNT;
            varint_accum_next = '0;
            varint_bytes_next = '0;
          end else if (b == OP_INSERT || b == OP_UPDATE || b == OP_DELETE) begin
            change_op_next   = b;
            parse_phase_next = PH_INDIRECT;
          end
        end
        PH_COUNT: begin
          varint_accum_next = vt_sat;
          varint_bytes_next = varint_bytes + 4'd1;
          if (vt_done) begin
            emit = 1'b1;
            if (vt_sat > {15'd0, column_limit} || vt_sat > 32'(MAX_COLUMNS)) begin
              parse_phase_next = PH_HALT;
              token.token_kind = K_ERROR;
              token.error_code = ERR_COLUMNS;
            end else begin
              column_count_next    = vt_sat[16:0];
              column_position_next = '0;
              parse_phase_next     = (vt_sat == 32'd0) ? PH_NAME : PH_PK;
              token.token_kind     = K_HEADER;
              token.token_value    = {32'd0, vt_sat};
            end
          end
        end
        PH_PK: begin
          column_position_next = pos_inc;
          if (ff_last) begin
            parse_phase_next = PH_NAME;
          end
          emit               = 1'b1;
          token.token_kind   = K_PK;
          token.token_value  = {56'd0, b};
          token.column_index = column_position[15:0];
        end
        PH_NAME: begin
          emit = 1'b1;
          if (b == 8'd0) begin
            parse_phase_next = PH_TOP;
            token.token_kind = K_NAMEEND;
          end else begin
            token.token_kind  = K_NAMEB;
            token.token_value = {56'd0, b};
          end
        end
        PH_INDIRECT: begin
          record_side_next     = (change_op == OP_INSERT);
          column_position_next = '0;
          parse_phase_next     = (column_count == 17'd0) ? PH_TOP : PH_FTYPE;
          emit                 = 1'b1;
          token.token_kind     = K_OP;
          token.token_value    = {48'd0, b, change_op};
          token.entry_done     = (column_count == 17'd0);
        end
        PH_FTYPE: begin
          if (b == FT_UNDEF || b == FT_NULL) begin
            fin              = 1'b1;
            emit             = 1'b1;
            token.token_kind = (b == FT_UNDEF) ? K_UNDEF : K_NULL;
          end else if (b >= FT_INT && b <= FT_BLOB) begin
            field_type_next   = b[2:0];
            value_shift_next  = '0;
            byte_counter_next = '0;
            varint_accum_next = '0;
            varint_bytes_next = '0;
            parse_phase_next  = (b <= FT_REAL) ? PH_FIXED : PH_LEN;
          end else begin
            parse_phase_next = PH_HALT;
            emit             = 1'b1;
            token.token_kind = K_ERROR;
            token.error_code = ERR_FIELDTYPE;
          end
        end
        PH_FIXED: begin
          value_shift_next  = {value_shift[55:0], b};
          byte_counter_next = byte_counter + 32'd1;
          if (byte_counter_next >= 32'd8) begin
            fin               = 1'b1;
            emit              = 1'b1;
            token.token_kind  = (field_type == FT_INT[2:0]) ? K_INT : K_REAL;
            token.token_value = value_shift_next;
          end
        end
        PH_LEN: begin
          varint_accum_next = vt_sat;
          varint_bytes_next = varint_bytes + 4'd1;
          if (vt_done) begin
            byte_counter_next = '0;
            emit              = 1'b1;
            token.token_kind  = (field_type == FT_TEXT[2:0]) ? K_TEXT : K_BLOB;
            token.token_value = {32'd0, vt_sat};
            if (vt_sat == 32'd0) begin
              fin = 1'b1;
            end else begin
              parse_phase_next = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          byte_counter_next = byte_counter + 32'd1;
          fin               = byte_counter_next >= varint_accum;
          emit              = 1'b1;
          token.token_kind  = K_PAYLOAD;
          token.token_value = {56'd0, b};
        end
        default: begin
        end
      endcase

      // field and payload tokens carry the column and record side
      if (parse_phase == PH_FTYPE || parse_phase == PH_FIXED ||
          parse_phase == PH_LEN || parse_phase == PH_PAYLOAD) begin
        if (token.token_kind != K_ERROR) begin
          token.column_index = column_position[15:0];
          token.in_new_row   = record_side;
        end
      end

      if (fin) begin
        token.entry_done     = ff_done;
        column_position_next = ff_flip ? 17'd0 : pos_inc;
        record_side_next     = ff_flip ? 1'b1 : record_side;
        parse_phase_next     = ff_done ? PH_TOP : PH_FTYPE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_TOP;
      column_count    <= '0;
      column_position <= '0;
      change_op       <= '0;
      record_side     <= 1'b0;
      field_type      <= '0;
      varint_accum    <= '0;
      varint_bytes    <= '0;
      value_shift     <= '0;
      byte_counter    <= '0;
    end else if (step) begin
      parse_phase     <= parse_phase_next;
      column_count    <= column_count_next;
      column_position <= column_position_next;
      change_op       <= change_op_next;
      record_side     <= record_side_next;
      field_type      <= field_type_next;
      varint_accum    <= varint_accum_next;
      varint_bytes    <= varint_bytes_next;
      value_shift     <= value_shift_next;
      byte_counter    <= byte_counter_next;
    end
  end

  `CSP_ASSERT(a_pos_in_range, column_position <= column_count, "column position past count")
  `CSP_ASSERT(a_varint_len, varint_bytes <= 4'd9, "varint longer than nine bytes")
  `CSP_ASSERT_IMP(a_count_cap, step && parse_phase_next == PH_PK, column_count_next != 17'd0, "pk phase with no columns")

endmodule

// ===== sim/changeset_token_checker.sv =====
`timescale 1ns / 1ps
module changeset_token_checker
  import csp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  csp_item_t   in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  csp_token_t  out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [16:0] cfg_data,
  output int          mismatches,
  output int          pending
);

  // shadow of the parser state
  logic [16:0] limit_reg;
  logic [3:0]  phase;
  logic [16:0] ncols;
  logic [16:0] colpos;
  logic [7:0]  op_code;
  logic        side_new;
  logic [2:0]  ftype;
  logic [31:0] vacc;
  logic [3:0]  vcnt;
  logic [63:0] fixed_val;
  logic [31:0] nbytes;

  csp_token_t token_q[$];
  int fail_count = 0;

  assign mismatches = fail_count;

  function automatic csp_token_t make_tok(input logic [3:0] kind, input logic [63:0] value,
                                          input logic [16:0] col, input logic nr,
                                          input logic done, input logic [1:0] err);
    csp_token_t t;
    t.token_kind   = kind;
    t.token_value  = value;
    t.column_index = col[15:0];
    t.in_new_row   = nr;
    t.entry_done   = done;
    t.error_code   = err;
    return t;
  endfunction

  // 7 bits per byte for the first eight bytes, a ninth byte gives all 8 bits
  function automatic bit varint_step(input logic [7:0] b);
    logic [63:0] t;
    if (vcnt >= 4'd8) t = ({32'd0, vacc} << 8) | {56'd0, b};
    else t = ({32'd0, vacc} << 7) | {57'd0, b[6:0]};
    if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
    vacc = t[31:0];
    vcnt = vcnt + 4'd1;
    return (vcnt >= 4'd9 || !b[7]);
  endfunction

  // step past a field; an update switches to the new record after the old one
  function automatic bit field_close();
    colpos = colpos + 17'd1;
    phase = PH_FTYPE;
    if (colpos >= ncols) begin
      if (!side_new && op_code == OP_UPDATE) begin
        side_new = 1'b1;
        colpos = '0;
        return 1'b0;
      end
      phase = PH_TOP;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit parse_word(input csp_item_t w, output csp_token_t t);
    logic [7:0]  b;
    logic [16:0] col;
    logic        sd;
    logic        done;
    logic [3:0]  was;
    b = w.in_byte;
    col = colpos;
    sd = side_new;
    t = '0;
    if (w.stream_end) begin
      was = phase;
      phase = PH_TOP;
      if (was == PH_TOP || was == PH_HALT) t = make_tok(K_END, '0, '0, 1'b0, 1'b0, ERR_NONE);
      else t = make_tok(K_ERROR, '0, '0, 1'b0, 1'b0, ERR_TRUNCATED);
      return 1'b1;
    end
    case (phase)
      PH_TOP: begin
        if (b == TAG_TABLE) begin
          phase = PH_COUNT;
          vacc = '0;
          vcnt = '0;
        end else if (b == OP_INSERT || b == OP_UPDATE || b == OP_DELETE) begin
          op_code = b;
          phase = PH_INDIRECT;
        end
        return 1'b0;
      end
      PH_COUNT: begin
        if (!varint_step(b)) return 1'b0;
        if (vacc > {15'd0, limit_reg} || vacc > MAX_COLUMNS) begin
          phase = PH_HALT;
          t = make_tok(K_ERROR, '0, '0, 1'b0, 1'b0, ERR_COLUMNS);
          return 1'b1;
        end
        ncols = vacc[16:0];
        colpos = '0;
        phase = (ncols == '0) ? PH_NAME : PH_PK;
        t = make_tok(K_HEADER, {47'd0, ncols}, '0, 1'b0, 1'b0, ERR_NONE);
        return 1'b1;
      end
      PH_PK: begin
        colpos = colpos + 17'd1;
        if (colpos >= ncols) phase = PH_NAME;
        t = make_tok(K_PK, {56'd0, b}, col, 1'b0, 1'b0, ERR_NONE);
        return 1'b1;
      end
      PH_NAME: begin
        if (b == 8'h00) begin
          phase = PH_TOP;
          t = make_tok(K_NAMEEND, '0, '0, 1'b0, 1'b0, ERR_NONE);
        end else begin
          t = make_tok(K_NAMEB, {56'd0, b}, '0, 1'b0, 1'b0, ERR_NONE);
        end
        return 1'b1;
      end
      PH_INDIRECT: begin
        side_new = (op_code == OP_INSERT);
        colpos = '0;
        done = (ncols == '0);
        phase = done ? PH_TOP : PH_FTYPE;
        t = make_tok(K_OP, {48'd0, b, op_code}, '0, 1'b0, done, ERR_NONE);
        return 1'b1;
      end
      PH_FTYPE: begin
        if (b == FT_UNDEF || b == FT_NULL) begin
          done = field_close();
          t = make_tok((b == FT_UNDEF) ? K_UNDEF : K_NULL, '0, col, sd, done, ERR_NONE);
          return 1'b1;
        end
        if (b >= FT_INT && b <= FT_BLOB) begin
          ftype = b[2:0];
          fixed_val = '0;
          nbytes = '0;
          vacc = '0;
          vcnt = '0;
          phase = (b <= FT_REAL) ? PH_FIXED : PH_LEN;
          return 1'b0;
        end
        phase = PH_HALT;
        t = make_tok(K_ERROR, '0, '0, 1'b0, 1'b0, ERR_FIELDTYPE);
        return 1'b1;
      end
      PH_FIXED: begin
        fixed_val = {fixed_val[55:0], b};
        nbytes = nbytes + 32'd1;
        if (nbytes < 32'd8) return 1'b0;
        done = field_close();
        t = make_tok((ftype == FT_INT) ? K_INT : K_REAL, fixed_val, col, sd, done, ERR_NONE);
        return 1'b1;
      end
      PH_LEN: begin
        if (!varint_step(b)) return 1'b0;
        nbytes = '0;
        if (vacc == '0) begin
          done = field_close();
        end else begin
          done = 1'b0;
          phase = PH_PAYLOAD;
        end
        t = make_tok((ftype == FT_TEXT) ? K_TEXT : K_BLOB, {32'd0, vacc}, col, sd, done,
                     ERR_NONE);
        return 1'b1;
      end
      PH_PAYLOAD: begin
        nbytes = nbytes + 32'd1;
        done = 1'b0;
        if (nbytes >= vacc) done = field_close();
        t = make_tok(K_PAYLOAD, {56'd0, b}, col, sd, done, ERR_NONE);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic note_failure(input string what, input csp_token_t e, input csp_token_t g);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t %s: expected kind %0d value %h col %0d new %0b done %0b err %0d, got kind %0d value %h col %0d new %0b done %0b err %0d",
               $realtime, what, e.token_kind, e.token_value, e.column_index, e.in_new_row,
               e.entry_done, e.error_code, g.token_kind, g.token_value, g.column_index,
               g.in_new_row, g.entry_done, g.error_code);
  endtask

  always @(posedge clk) begin
    csp_token_t want;
    csp_token_t tok;
    if (rst) begin
      limit_reg = COLUMN_LIMIT_RESET;
      phase = PH_TOP;
      ncols = '0;
      colpos = '0;
      op_code = '0;
      side_new = 1'b0;
      ftype = '0;
      vacc = '0;
      vcnt = '0;
      fixed_val = '0;
      nbytes = '0;
      token_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (token_q.size() == 0) begin
          note_failure("token with nothing pending", '0, out_data);
        end else begin
          want = token_q.pop_front();
          if (out_data.token_kind !== want.token_kind ||
              out_data.token_value !== want.token_value ||
              out_data.column_index !== want.column_index ||
              out_data.in_new_row !== want.in_new_row ||
              out_data.entry_done !== want.entry_done ||
              out_data.error_code !== want.error_code)
            note_failure("token mismatch", want, out_data);
        end
      end
      if (cfg_valid && cfg_ready) limit_reg = cfg_data;
      if (in_valid && in_ready)
        if (parse_word(in_data, tok)) token_q.insert(token_q.size(), tok);
    end
    pending <= token_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import csp_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  csp_item_t   in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  csp_token_t  out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [16:0] cfg_data = '0;

  int mismatches;
  int pending;
  int send_idle = 0;
  int stall_pct = 0;
  bit hold_go = 1'b0;

  csp_item_t   words[$];
  int unsigned gen_cols = 0;
  logic [16:0] gen_limit = COLUMN_LIMIT_RESET;

  always #4 clk = ~clk;

  changeset_stream_parser_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  changeset_token_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    #3_000_000;
    $display("tb_top failed");
    $finish;
  end

  // token sink: random stalls plus one long hold-off
  int hold_left = 0;
  bit hold_used = 1'b0;
  always @(posedge clk) begin
    if (hold_go && !hold_used) begin
      hold_used = 1'b1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_word(input csp_item_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic play();
    foreach (words[i]) send_word(words[i]);
    words.delete();
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // words that make no token may still be in the pipe
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [16:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    gen_limit = v;
  endtask

  task automatic put(input logic [7:0] b);
    csp_item_t w;
    w.in_byte = b;
    w.stream_end = 1'b0;
    words.insert(words.size(), w);
  endtask

  task automatic put_end();
    csp_item_t w;
    w.in_byte = 8'($urandom_range(255));
    w.stream_end = 1'b1;
    words.insert(words.size(), w);
  endtask

  task automatic put_varint(input int unsigned v);
    int g;
    g = 1;
    while (g < 5 && (v >> (7 * g)) != 0) g++;
    // a leading empty group leaves the value unchanged
    if ($urandom_range(3) == 0) put(8'h80);
    for (int i = g - 1; i >= 0; i--)
      put(8'((v >> (7 * i)) & 32'h7f) | ((i > 0) ? 8'h80 : 8'h00));
  endtask

  // nine-byte varint far beyond 32 bits
  task automatic put_huge_varint();
    put(8'hFF);
    repeat (7) put(8'h80 | 8'($urandom_range(127)));
    put(8'($urandom_range(255)));
  endtask

  task automatic put_field();
    int r;
    int unsigned len;
    logic [7:0] kind;
    r = $urandom_range(99);
    if (r < 3) begin
      put(8'($urandom_range(FT_NULL + 1, 255)));
    end else if (r < 20) begin
      put(FT_UNDEF);
    end else if (r < 37) begin
      put(FT_NULL);
    end else if (r < 65) begin
      kind = (r < 51) ? FT_INT : FT_REAL;
      put(kind);
      r = $urandom_range(3);
      repeat (8) put((r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(255)));
    end else begin
      kind = (r < 83) ? FT_TEXT : FT_BLOB;
      put(kind);
      len = ($urandom_range(9) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 4);
      put_varint(len);
      repeat (len) put(8'($urandom_range(255)));
    end
  endtask

  task automatic put_table(input int unsigned n);
    put(TAG_TABLE);
    put_varint(n);
    repeat (n) put(8'($urandom_range(255)));
    repeat ($urandom_range(0, 6)) put(8'($urandom_range(1, 255)));
    put(8'h00);
  endtask

  task automatic put_change();
    logic [7:0] ops[3];
    logic [7:0] op;
    ops = '{OP_INSERT, OP_UPDATE, OP_DELETE};
    op = ops[$urandom_range(2)];
    put(op);
    put(8'($urandom_range(255)));
    repeat (((op == OP_UPDATE) ? 2 : 1) * gen_cols) put_field();
  endtask

  // one changeset, mostly well formed, sometimes cut short or broken
  task automatic make_changeset();
    int unsigned n;
    int c;
    int start;
    int cut;
    bit accepted;
    start = words.size();
    if ($urandom_range(9) == 0) put(8'($urandom_range(255)));
    c = $urandom_range(99);
    if (c < 3) begin
      put(TAG_TABLE);
      put_huge_varint();
      repeat ($urandom_range(0, 3)) put(8'($urandom_range(255)));
      put_end();
      return;
    end
    if (c < 7) n = gen_limit + 1;
    else if (c < 11) n = gen_limit;
    else n = $urandom_range(0, 4);
    accepted = (n <= gen_limit && n <= MAX_COLUMNS);
    if (n > 8) begin
      // wide header: check the count, then give up a few columns in
      put(TAG_TABLE);
      put_varint(n);
      repeat (3) put(8'($urandom_range(255)));
      put_end();
      if (accepted) gen_cols = n;
      return;
    end
    put_table(n);
    if (accepted) begin
      gen_cols = n;
      repeat ($urandom_range(1, 3)) put_change();
    end else begin
      repeat ($urandom_range(1, 4)) put(8'($urandom_range(255)));
    end
    if ($urandom_range(3) == 0) put(8'($urandom_range(255)));
    if ($urandom_range(99) < 15 && words.size() > start + 1) begin
      cut = $urandom_range(start + 1, words.size() - 1);
      while (words.size() > cut) void'(words.pop_back());
    end
    put_end();
  endtask

  initial begin
    logic [16:0] limits[6];
    int idle_tab[4];
    int stall_tab[4];
    int sent;
    bit paused;
    limits = '{COLUMN_LIMIT_RESET, 17'd0, 17'd3, 17'd1, 17'd65536, 17'd0};
    limits[5] = 17'($urandom_range(4, 12));
    idle_tab = '{0, 76, 0, 12};
    stall_tab = '{0, 0, 76, 12};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // end at top level, change with no header, stray byte, empty name,
    // empty text, blob then null, bad field type, end after an error,
    // stream cut inside a column count
    put_end();
    put(OP_DELETE); put(8'h80);
    put(8'hAA);
    put(TAG_TABLE); put(8'h01); put(8'h00); put(8'h00);
    put(OP_INSERT); put(8'hFF); put(FT_TEXT); put(8'h00);
    put(OP_UPDATE); put(8'h01); put(FT_BLOB); put(8'h01); put(8'hFF); put(FT_NULL);
    put(OP_DELETE); put(8'h00); put(8'h07);
    put(8'h42); put_end();
    put(TAG_TABLE); put(8'h81); put_end();
    gen_cols = 1;
    play();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) write_limit(limits[ph]);
      send_idle = idle_tab[ph % 4];
      stall_pct <= stall_tab[ph % 4];
      if (ph == 0) hold_go <= 1'b1;
      sent = 0;
      paused = 1'b0;
      while (sent < 115) begin
        make_changeset();
        sent += words.size();
        play();
        if (!paused && sent >= 57) begin
          wait_idle();
          paused = 1'b1;
        end
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

// ===== changeset_stream_parser_core.f =====
+incdir+rtl/core
rtl/core/csp_pkg.sv
rtl/core/csp_in_reg.sv
rtl/core/csp_parser.sv
rtl/core/changeset_stream_parser_core.sv
sim/changeset_token_checker.sv
sim/tb_top.sv
